@@ rtl/bitmap_font_glyph_blitter_macros.svh @@
// Assertion macros for the glyph blitter.
// Pure text macros; no dependencies.
`ifndef BITMAP_FONT_GLYPH_BLITTER_MACROS_SVH
`define BITMAP_FONT_GLYPH_BLITTER_MACROS_SVH

// same-cycle implication
`define BFG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BFG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bfg_pkg.sv @@
// Shared types, constants and the 5x7 font table for the glyph blitter.
// No dependencies.
`timescale 1ns / 1ps

package bfg_pkg;

   localparam int FRAME_W       = 13;
   localparam int COORD_W       = 12;
   localparam int PEN_W         = 14;
   localparam int LINE_W        = 13;
   localparam int CLR_W         = 8;
   localparam int CODE_W        = 8;
   localparam int GIDX_W        = 7;
   localparam int GLYPH_COLS    = 5;
   localparam int GLYPH_ROWS    = 7;
   localparam int GLYPH_BITS    = GLYPH_COLS * GLYPH_ROWS;
   localparam int CNT_W         = 3;
   localparam int FIRST_CODE    = 32;
   localparam int LAST_GLYPH    = 94;
   localparam int ADVANCE       = 6;
   localparam int PEN_TOP       = 8191;
   localparam int MAX_FRAME_DIM = 4096;
   localparam int FRAME_W_RESET = 640;
   localparam int FRAME_H_RESET = 480;
   localparam int QDEPTH        = 2;
   localparam int QPTR_W        = $clog2(QDEPTH);
   localparam int QCNT_W        = $clog2(QDEPTH + 1);
   localparam int APB_DATA_W    = 32;
   localparam int APB_ADDR_W    = 3;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_idx_type;

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } back_state_type;

   // one classified character: surviving pixel mask plus placement and color
   typedef struct packed {
      logic [GLYPH_BITS-1:0] mask;
      logic [COORD_W-1:0]    base_x;
      logic [COORD_W-1:0]    base_y;
      logic [CLR_W-1:0]      red;
      logic [CLR_W-1:0]      green;
      logic [CLR_W-1:0]      blue;
   } job_type;

   // column 0 in the top byte, column 4 in the bottom byte; bit 0 = bottom row
   localparam logic [8*GLYPH_COLS-1:0] GLYPH_ROM [0:LAST_GLYPH] = '{
      40'h0000000000, 40'h00005F0000,
      40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462,
      40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00,
      40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808,
      40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539,
      40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E,
      40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E,
      40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941,
      40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100,
      40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F,
      40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F,
      40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807,
      40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00,
      40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478,
      40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h0C5252523E,
      40'h7F08040478, 40'h00447D4000,
      40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478,
      40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C,
      40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C,
      40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800,
      40'h1008100800
   };

endpackage

@@ rtl/bfg_front.sv @@
// Front end: frame size registers, pen state, glyph lookup and clip mask.
// Depends on bfg_pkg.
`timescale 1ns / 1ps

module bfg_front
   import bfg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [APB_ADDR_W-1:0]  paddr,
   input  logic [APB_DATA_W-1:0]  pwdata,
   output logic [APB_DATA_W-1:0]  prdata,
   input  logic                   push,
   input  logic                   q_full,
   input  logic                   req_new_string,
   input  logic signed [12:0]     req_origin_x,
   input  logic signed [12:0]     req_origin_y,
   input  logic [CODE_W-1:0]      req_char_code,
   input  logic [CLR_W-1:0]       req_red,
   input  logic [CLR_W-1:0]       req_green,
   input  logic [CLR_W-1:0]       req_blue,
   output logic                   job_push,
   output job_type                job
);

   logic [FRAME_W-1:0] frame_width_ff, frame_width_in;
   logic [FRAME_W-1:0] frame_height_ff, frame_height_in;
   logic [PEN_W-1:0]   pen_x_ff, pen_x_in;
   logic [LINE_W-1:0]  line_y_ff, line_y_in;

   logic                   csr_write;
   reg_idx_type            csr_idx;
   logic [PEN_W-1:0]       start_x;
   logic [LINE_W-1:0]      start_y;
   logic [FRAME_W-1:0]     wlim, hlim;
   logic [GIDX_W-1:0]      gidx;
   logic [8*GLYPH_COLS-1:0] glyph;
   logic [PEN_W:0]         px [GLYPH_COLS];
   logic [LINE_W:0]        py [GLYPH_ROWS];
   logic [GLYPH_COLS-1:0]  col_ok;
   logic [GLYPH_ROWS-1:0]  row_ok;
   logic [GLYPH_BITS-1:0]  mask;

   // register access; byte offset within a word is ignored
   assign csr_write = psel & penable & pwrite;
   assign csr_idx   = reg_idx_type'(paddr[2]);

   always_comb begin
      unique case (csr_idx)
         REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_FRAME_WIDTH:  frame_width_in  = pwdata[FRAME_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = pwdata[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   assign job_push = push & ~q_full;

   always_comb begin
      start_x = req_new_string ? {req_origin_x[12], req_origin_x} : pen_x_ff;
      start_y = req_new_string ? req_origin_y : line_y_ff;
      wlim = (frame_width_ff > FRAME_W'(MAX_FRAME_DIM)) ? FRAME_W'(MAX_FRAME_DIM)
                                                        : frame_width_ff;
      hlim = (frame_height_ff > FRAME_W'(MAX_FRAME_DIM)) ? FRAME_W'(MAX_FRAME_DIM)
                                                         : frame_height_ff;
      if ((req_char_code >= CODE_W'(FIRST_CODE)) &&
          (req_char_code <= CODE_W'(FIRST_CODE + LAST_GLYPH)))
         gidx = GIDX_W'(req_char_code - CODE_W'(FIRST_CODE));
      else
         gidx = '0;
      glyph = GLYPH_ROM[gidx];

      for (int c = 0; c < GLYPH_COLS; c++) begin
         px[c]     = {start_x[PEN_W-1], start_x} + (PEN_W+1)'(c);
         col_ok[c] = ~px[c][PEN_W] && (px[c] < (PEN_W+1)'(wlim));
      end
      // bit r of a column lands on row top + 6 - r
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         py[r]     = {start_y[LINE_W-1], start_y} + (LINE_W+1)'(GLYPH_ROWS - 1 - r);
         row_ok[r] = ~py[r][LINE_W] && (py[r] < (LINE_W+1)'(hlim));
      end
      for (int c = 0; c < GLYPH_COLS; c++) begin
         for (int r = 0; r < GLYPH_ROWS; r++) begin
            mask[c*GLYPH_ROWS + r] = glyph[(GLYPH_COLS-1-c)*8 + r] & col_ok[c] & row_ok[r];
         end
      end

      job.mask   = mask;
      job.base_x = start_x[COORD_W-1:0];
      job.base_y = start_y[COORD_W-1:0];
      job.red    = req_red;
      job.green  = req_green;
      job.blue   = req_blue;
   end

   // pen advances by one cell and sticks at its top value
   always_comb begin
      pen_x_in  = pen_x_ff;
      line_y_in = line_y_ff;
      if (job_push) begin
         line_y_in = start_y;
         if ($signed(start_x) > $signed(PEN_W'(PEN_TOP - ADVANCE)))
            pen_x_in = PEN_W'(PEN_TOP);
         else
            pen_x_in = start_x + PEN_W'(ADVANCE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_W'(FRAME_W_RESET);
         frame_height_ff <= FRAME_W'(FRAME_H_RESET);
         pen_x_ff        <= '0;
         line_y_ff       <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         pen_x_ff        <= pen_x_in;
         line_y_ff       <= line_y_in;
      end
   end

endmodule

@@ rtl/bfg_queue.sv @@
// Short job queue between the front end and the pixel scanner.
// Depends on bfg_pkg.
`timescale 1ns / 1ps

module bfg_queue
   import bfg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type job_in,
   input  logic    pop,
   output job_type job_out,
   output logic    full,
   output logic    empty
);

   job_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign job_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= job_in;
   end

endmodule

@@ rtl/bfg_back.sv @@
// Back end: walks a job's pixel mask and loads the result register.
// Depends on bfg_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "bitmap_font_glyph_blitter_macros.svh"

module bfg_back
   import bfg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  job_type            job,
   output logic               q_pop,
   input  logic               pop,
   output logic               empty,
   output logic               rsp_write_enable,
   output logic [COORD_W-1:0] rsp_pixel_x,
   output logic [COORD_W-1:0] rsp_pixel_y,
   output logic [CLR_W-1:0]   rsp_out_red,
   output logic [CLR_W-1:0]   rsp_out_green,
   output logic [CLR_W-1:0]   rsp_out_blue,
   output logic               rsp_last
);

   back_state_type        state_ff, state_in;
   logic [GLYPH_BITS-1:0] mask_ff;
   logic [CNT_W-1:0]      row_ff, col_ff;
   logic [COORD_W-1:0]    base_x_ff, base_y_ff;
   logic [CLR_W-1:0]      red_ff, green_ff, blue_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_we_ff, rsp_last_ff;
   logic [COORD_W-1:0]    rsp_x_ff, rsp_y_ff;
   logic [CLR_W-1:0]      rsp_r_ff, rsp_g_ff, rsp_b_ff;

   logic out_free, step, emit, emit_null, rest_zero;

   assign out_free  = ~rsp_valid_ff | pop;
   assign rest_zero = (mask_ff[GLYPH_BITS-1:1] == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!q_empty && out_free && (job.mask != '0)) state_in = BK_SCAN;
         BK_SCAN: if (step && rest_zero) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // a cell with no pixel is skipped even while the result register is held
   always_comb begin
      q_pop     = 1'b0;
      step      = 1'b0;
      unique case (state_ff)
         BK_IDLE: q_pop = ~q_empty & out_free;
         BK_SCAN: step  = out_free | ~mask_ff[0];
         default: ;
      endcase
      emit      = step & mask_ff[0];
      emit_null = q_pop & (job.mask == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit || emit_null)
            rsp_valid_ff <= 1'b1;
         else if (pop)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         mask_ff   <= job.mask;
         base_x_ff <= job.base_x;
         base_y_ff <= job.base_y;
         red_ff    <= job.red;
         green_ff  <= job.green;
         blue_ff   <= job.blue;
         row_ff    <= '0;
         col_ff    <= '0;
      end else if (step) begin
         mask_ff <= mask_ff >> 1;
         if (row_ff == CNT_W'(GLYPH_ROWS - 1)) begin
            row_ff <= '0;
            col_ff <= col_ff + 1'b1;
         end else begin
            row_ff <= row_ff + 1'b1;
         end
      end

      if (emit) begin
         rsp_we_ff   <= 1'b1;
         rsp_x_ff    <= base_x_ff + COORD_W'(col_ff);
         rsp_y_ff    <= base_y_ff + COORD_W'(GLYPH_ROWS - 1) - COORD_W'(row_ff);
         rsp_r_ff    <= red_ff;
         rsp_g_ff    <= green_ff;
         rsp_b_ff    <= blue_ff;
         rsp_last_ff <= rest_zero;
      end else if (emit_null) begin
         rsp_we_ff   <= 1'b0;
         rsp_x_ff    <= '0;
         rsp_y_ff    <= '0;
         rsp_r_ff    <= '0;
         rsp_g_ff    <= '0;
         rsp_b_ff    <= '0;
         rsp_last_ff <= 1'b1;
      end
   end

   assign empty            = ~rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_pixel_x      = rsp_x_ff;
   assign rsp_pixel_y      = rsp_y_ff;
   assign rsp_out_red      = rsp_r_ff;
   assign rsp_out_green    = rsp_g_ff;
   assign rsp_out_blue     = rsp_b_ff;
   assign rsp_last         = rsp_last_ff;

   `BFG_ASSERT_IMP(a_null_word_is_last, clock, reset, rsp_valid_ff && !rsp_we_ff, rsp_last_ff, "null word without last")
   `BFG_ASSERT_IMP(a_scan_has_pixels, clock, reset, state_ff == BK_SCAN, mask_ff != '0, "scan with empty mask")
   `BFG_ASSERT_IMP(a_scan_in_cell, clock, reset, state_ff == BK_SCAN, (row_ff < CNT_W'(GLYPH_ROWS)) && (col_ff < CNT_W'(GLYPH_COLS)), "scan outside glyph cell")
   `BFG_ASSERT_NEXT(a_scan_end_idle, clock, reset, (state_ff == BK_SCAN) && step && rest_zero, state_ff == BK_IDLE, "scan ran past last pixel")

endmodule

@@ rtl/bitmap_font_glyph_blitter.sv @@
// Top level of the 5x7 glyph blitter: front end, job queue, pixel scanner.
// Depends on bfg_pkg, bfg_front, bfg_queue and bfg_back.
//
//   channel   direction  handshake           payload
//   req       in         push / full         new_string, origin, char_code, color
//   rsp       out        pop / empty         write_enable, pixel x/y, color, last
//   config    in         APB psel/penable    frame_width @0, frame_height @4
//
// A character is classified in the cycle it is accepted, then waits in a
// two-deep job queue. The scanner loads a job into its registers, then
// steps through the glyph cells one per cycle and stops after the last
// surviving pixel; a character with no surviving pixel gives one null
// word. The walk stalls on a pixel cell while the result register holds
// an unaccepted word. Synchronous reset restores 640x480 and pen 0.

`timescale 1ns / 1ps

module bitmap_font_glyph_blitter
   import bfg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_new_string,
   input  logic signed [12:0]    req_origin_x,
   input  logic signed [12:0]    req_origin_y,
   input  logic [CODE_W-1:0]     req_char_code,
   input  logic [CLR_W-1:0]      req_red,
   input  logic [CLR_W-1:0]      req_green,
   input  logic [CLR_W-1:0]      req_blue,
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_write_enable,
   output logic [COORD_W-1:0]    rsp_pixel_x,
   output logic [COORD_W-1:0]    rsp_pixel_y,
   output logic [CLR_W-1:0]      rsp_out_red,
   output logic [CLR_W-1:0]      rsp_out_green,
   output logic [CLR_W-1:0]      rsp_out_blue,
   output logic                  rsp_last
);

   job_type front_job, back_job;
   logic    job_push, q_full, q_empty, q_pop;

   assign pready = 1'b1;
   assign full   = q_full;

   bfg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .push           (push),
      .q_full         (q_full),
      .req_new_string (req_new_string),
      .req_origin_x   (req_origin_x),
      .req_origin_y   (req_origin_y),
      .req_char_code  (req_char_code),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .job_push       (job_push),
      .job            (front_job)
   );

   bfg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .job_in  (front_job),
      .pop     (q_pop),
      .job_out (back_job),
      .full    (q_full),
      .empty   (q_empty)
   );

   bfg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .job              (back_job),
      .q_pop            (q_pop),
      .pop              (pop),
      .empty            (empty),
      .rsp_write_enable (rsp_write_enable),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_last         (rsp_last)
   );

endmodule
